### rtl/lhp_pkg.sv
// shared types, codes and helper functions for the link layer header parser
package lhp_pkg;

  localparam int MAX_VLAN_TAGS = 4;

  localparam logic [2:0] LINK_RAW    = 3'd0;
  localparam logic [2:0] LINK_ETH    = 3'd1;
  localparam logic [2:0] LINK_TAGGED = 3'd2;
  localparam logic [2:0] LINK_PPP    = 3'd3;
  localparam logic [2:0] LINK_HDLC   = 3'd4;
  localparam logic [2:0] LINK_COOKED = 3'd5;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_SHORT = 2'd1;
  localparam logic [1:0] STAT_NO_MAGIC  = 2'd2;

  localparam logic [7:0]  FLAG_NO_L2 = 8'h02;
  localparam logic [7:0]  FLAG_EXT   = 8'h80;
  localparam logic [15:0] TYPE_VLAN  = 16'h8100;
  localparam logic [15:0] TYPE_IP4   = 16'h0800;
  localparam logic [15:0] TYPE_IP6   = 16'h86DD;
  localparam logic [15:0] TYPE_PPP_IP = 16'h0021;

  typedef enum logic [3:0] {
    PH_HEAD = 4'd0,
    PH_EXT  = 4'd1,
    PH_IP   = 4'd2,
    PH_ETH  = 4'd3,
    PH_DONE = 4'd4,
    PH_DEEP = 4'd5
  } phase_t;

  function automatic logic [15:0] ip_type(input logic [7:0] b);
    logic [15:0] t;
    unique case (b[7:4])
      4'd4:    t = TYPE_IP4;
      4'd6:    t = TYPE_IP6;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

  // "MGC" prefix of the vendor header
  function automatic logic [7:0] magic_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0:    c = 8'h4D;
      2'd1:    c = 8'h47;
      2'd2:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/lhp_intf.sv
// handshake channel interfaces for the link layer header parser
interface lhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface lhp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] proto_type;
  logic [15:0] l2_length;
  logic [1:0]  status;
  modport source (output valid, proto_type, l2_length, status, input ready);
  modport sink   (input valid, proto_type, l2_length, status, output ready);
endinterface

interface lhp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_type;
  modport source (output valid, link_type, input ready);
  modport sink   (input valid, link_type, output ready);
endinterface

### rtl/link_layer_header_parser.sv
// link layer header parser top level: byte stream in, protocol type and header length out
// Takes one packet byte per clock with no bubbles, as long as the result register is not
// blocked; a byte passes an input register, then the header state and, on the last byte,
// the result register. Only a last beat that meets a full, stalled result register holds
// the input. The link type is written through cfg_bus, which is always ready, and must
// only change while no beat is in flight.
module link_layer_header_parser
  import lhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lhp_in_if.sink     in_bus,
  lhp_out_if.source  out_bus,
  lhp_cfg_if.sink    cfg_bus
);

  logic [2:0]  link_r;

  logic        s_vld_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;

  logic [15:0] idx_r, idx_nxt;
  logic [16:0] off_r, off_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [2:0]  tag_r, tag_nxt;
  phase_t      ph_r, ph_nxt;
  logic        bad_r, bad_nxt;

  logic        out_vld_r;
  logic [15:0] et_r, et_nxt;
  logic [15:0] len_r, len_nxt;
  logic [1:0]  st_r, st_nxt;

  logic        take;
  logic        adv;
  logic        stall;
  logic        eth_run;
  logic        fix_run;
  logic [15:0] fix_pos;
  logic [17:0] eth_pos;
  logic [17:0] idx_w;
  logic [15:0] t_join;
  logic [15:0] f_join;

  assign stall          = s_vld_r && s_last_r && out_vld_r && !out_bus.ready;
  assign adv            = s_vld_r && !stall;
  assign in_bus.ready   = !stall;
  assign cfg_bus.ready  = 1'b1;

  assign take    = (idx_r != 16'hFFFF);
  assign idx_w   = {2'b00, idx_r};
  assign eth_pos = {1'b0, off_r} + 18'd12 + {13'd0, tag_r, 2'b00};
  assign t_join  = type_r | {8'h00, s_byte_r};

  // per-byte header state update
  always_comb begin
    idx_nxt  = take ? idx_r + 16'd1 : idx_r;
    off_nxt  = off_r;
    type_nxt = type_r;
    flag_nxt = flag_r;
    tag_nxt  = tag_r;
    ph_nxt   = ph_r;
    bad_nxt  = bad_r;
    eth_run  = 1'b0;
    fix_run  = 1'b0;
    fix_pos  = 16'd2;
    f_join   = t_join;
    if (take) begin
      unique case (link_r)
        LINK_RAW: begin
          if (ph_r == PH_HEAD && idx_r == 16'd0) begin
            type_nxt = ip_type(s_byte_r);
            ph_nxt   = PH_DONE;
          end
        end
        LINK_ETH: begin
          if (ph_r == PH_HEAD || ph_r == PH_ETH) begin
            ph_nxt  = PH_ETH;
            eth_run = 1'b1;
          end
        end
        LINK_TAGGED: begin
          unique case (ph_r)
            PH_HEAD: begin
              if (idx_r < 16'd3) begin
                if (s_byte_r != magic_char(idx_r[1:0])) bad_nxt = 1'b1;
              end else if (idx_r == 16'd3) begin
                flag_nxt = s_byte_r;
                if ((s_byte_r & FLAG_EXT) != 8'h00) begin
                  ph_nxt = PH_EXT;
                end else begin
                  off_nxt = 17'd4;
                  ph_nxt  = ((s_byte_r & FLAG_NO_L2) != 8'h00) ? PH_IP : PH_ETH;
                end
              end
            end
            PH_EXT: begin
              if (idx_r == 16'd4) begin
                off_nxt = {1'b0, s_byte_r, 8'h00};
              end else if (idx_r == 16'd5) begin
                off_nxt = (off_r | {9'd0, s_byte_r}) + 17'd6;
                ph_nxt  = ((flag_r & FLAG_NO_L2) != 8'h00) ? PH_IP : PH_ETH;
              end
            end
            PH_IP: begin
              if ({1'b0, idx_r} == off_r) begin
                type_nxt = ip_type(s_byte_r);
                ph_nxt   = PH_DONE;
              end
            end
            PH_ETH:  eth_run = 1'b1;
            default: ;
          endcase
        end
        LINK_PPP, LINK_HDLC: begin
          fix_run = (ph_r == PH_HEAD);
          fix_pos = 16'd2;
        end
        LINK_COOKED: begin
          fix_run = (ph_r == PH_HEAD);
          fix_pos = 16'd14;
        end
        default: ;
      endcase
    end

    if (eth_run) begin
      if (idx_w == eth_pos) begin
        type_nxt = {s_byte_r, 8'h00};
      end else if (idx_w == eth_pos + 18'd1) begin
        type_nxt = t_join;
        if (t_join == TYPE_VLAN) begin
          if (tag_r < 3'(MAX_VLAN_TAGS)) tag_nxt = tag_r + 3'd1;
          else ph_nxt = PH_DEEP;
        end else begin
          ph_nxt = PH_DONE;
        end
      end
    end

    if (fix_run) begin
      if (idx_r == fix_pos) begin
        type_nxt = {s_byte_r, 8'h00};
      end else if (idx_r == fix_pos + 16'd1) begin
        if (link_r == LINK_PPP && t_join == TYPE_PPP_IP) f_join = TYPE_IP4;
        type_nxt = f_join;
        ph_nxt   = PH_DONE;
      end
    end
  end

  // result of a packet from the state after its last byte
  always_comb begin
    et_nxt  = 16'h0000;
    len_nxt = 16'h0000;
    st_nxt  = STAT_OK;
    unique case (link_r)
      LINK_RAW: begin
        if (ph_nxt == PH_DONE) et_nxt = type_nxt;
      end
      LINK_ETH, LINK_TAGGED: begin
        if (link_r == LINK_TAGGED && idx_nxt < 16'd4) begin
          st_nxt = STAT_TOO_SHORT;
        end else if (link_r == LINK_TAGGED && bad_nxt) begin
          st_nxt = STAT_NO_MAGIC;
        end else if (ph_nxt == PH_DONE) begin
          et_nxt = type_nxt;
          if (link_r == LINK_TAGGED && (flag_nxt & FLAG_NO_L2) != 8'h00)
            len_nxt = off_nxt[15:0];
          else
            len_nxt = off_nxt[15:0] + 16'd14 + {11'd0, tag_nxt, 2'b00};
        end else begin
          st_nxt = STAT_TOO_SHORT;
        end
      end
      LINK_PPP, LINK_HDLC, LINK_COOKED: begin
        if (ph_nxt == PH_DONE) begin
          et_nxt  = type_nxt;
          len_nxt = (link_r == LINK_COOKED) ? 16'd16 : 16'd4;
        end else begin
          st_nxt = STAT_TOO_SHORT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= LINK_ETH;
    end else if (cfg_bus.valid) begin
      link_r <= cfg_bus.link_type;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      s_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      s_byte_r <= in_bus.data_byte;
      s_last_r <= in_bus.last_byte;
    end
  end

  // packet state, cleared after every last beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 16'd0;
      off_r  <= 17'd0;
      type_r <= 16'd0;
      flag_r <= 8'd0;
      tag_r  <= 3'd0;
      ph_r   <= PH_HEAD;
      bad_r  <= 1'b0;
    end else if (adv) begin
      if (s_last_r) begin
        idx_r  <= 16'd0;
        off_r  <= 17'd0;
        type_r <= 16'd0;
        flag_r <= 8'd0;
        tag_r  <= 3'd0;
        ph_r   <= PH_HEAD;
        bad_r  <= 1'b0;
      end else begin
        idx_r  <= idx_nxt;
        off_r  <= off_nxt;
        type_r <= type_nxt;
        flag_r <= flag_nxt;
        tag_r  <= tag_nxt;
        ph_r   <= ph_nxt;
        bad_r  <= bad_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && s_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_last_r) begin
      et_r  <= et_nxt;
      len_r <= len_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.proto_type = et_r;
  assign out_bus.l2_length  = len_r;
  assign out_bus.status     = st_r;

endmodule
